### hw/rtl/ppt_pkg.sv
// ppt_pkg: shared types and fixed constants for the pose point transform
// holds the transaction structs, cordic state type and arctangent table
// no dependencies
package ppt_pkg;

    // field widths of the transactions
    localparam int COORD_W = 32;
    localparam int ANGLE_W = 16;

    // heading is widened to a full-turn fraction of this many bits
    localparam int TURN_W = 32;
    localparam int QUAD_W = 2;

    // sine and cosine in q.15
    localparam int TRIG_W       = 16;
    localparam int TRIG_FRAC    = 15;
    localparam int TRIG_ONE_MAX = 32767;

    // cordic rotation, scale 2^30, angles in 2^-32 turn
    localparam int CORDIC_STEPS    = 16;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int STEP_IDX_W      = $clog2(CORDIC_STEPS);
    localparam int CX_W            = 34;
    localparam int CZ_W            = 32;

    // start vector x is the inverse of the cordic gain
    localparam logic signed [CX_W-1:0] CORDIC_START = CX_W'(652032874);

    localparam logic signed [CZ_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458908, 32'sd85004756,
        32'sd42667330,  32'sd21354465,  32'sd10679843,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] pose_x;
        logic signed [COORD_W-1:0] pose_y;
        logic        [ANGLE_W-1:0] heading;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
    } t_out_item;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } t_cordic;

endpackage

### hw/rtl/pose_point_transform.sv
// pose_point_transform: planar rigid-body transform of one footprint vertex
// pipelined cordic sine/cosine, rotation multipliers, rounding and saturation
// depends on ppt_pkg
//
// One transaction carries a robot pose (pose_x, pose_y in Q15.16, heading in
// 1/65536 turn) and one vertex in the robot frame; the result is the vertex
// rotated by the heading and moved by the pose, saturated to the signed 32-bit
// range. The block takes a new transaction every cycle unless the output is
// stalled and every stage is full. From input acceptance to output valid a
// transaction passes eight stages of the 16-iteration cordic (two iterations
// per stage), one stage for q.15 rounding and quadrant mapping, one for the
// four 32x16 multipliers, one for the rotation sums with rounding, and the
// output register that adds the pose and saturates. Each stage carries its own
// valid bit and ready is resolved per stage, so empty stages fill up while the
// output is stalled and a stalled result never blocks input until every stage
// holds a transaction. There is no configuration and no state beyond the
// pipeline, and reset only clears the valid bits.
module pose_point_transform
    import ppt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // stage numbering: cordic stages first, then the arithmetic tail
    localparam int ST_TRIG = CORDIC_STAGES;
    localparam int ST_MUL  = CORDIC_STAGES + 1;
    localparam int ST_ROT  = CORDIC_STAGES + 2;
    localparam int ST_OUT  = CORDIC_STAGES + 3;
    localparam int NUM_ST  = CORDIC_STAGES + 4;

    localparam int PROD_W = COORD_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int ROT_W  = SUM_W - TRIG_FRAC;
    localparam int OSUM_W = ROT_W + 1;
    localparam int Q_W    = CX_W + 1 - TRIG_FRAC;

    localparam int ROUND_HALF = 1 << (TRIG_FRAC - 1);

    localparam logic signed [Q_W-1:0] Q_HI = Q_W'(TRIG_ONE_MAX);
    localparam logic signed [Q_W-1:0] Q_LO = -Q_HI;

    // quadrant codes from the top bits of the turn fraction
    localparam logic [QUAD_W-1:0] QUAD_0 = 2'd0;
    localparam logic [QUAD_W-1:0] QUAD_1 = 2'd1;
    localparam logic [QUAD_W-1:0] QUAD_2 = 2'd2;
    localparam logic [QUAD_W-1:0] QUAD_3 = 2'd3;

    // one cordic micro-rotation, shifts are floors
    function automatic t_cordic cordic_step(input t_cordic a, input logic [STEP_IDX_W-1:0] i);
        logic signed [CX_W-1:0] dx;
        logic signed [CX_W-1:0] dy;
        t_cordic                r;
        dx = a.y >>> i;
        dy = a.x >>> i;
        if (!a.z[CZ_W-1]) begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - ATAN_TURNS[i];
        end else begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + ATAN_TURNS[i];
        end
        return r;
    endfunction

    // round the 2^30 scaled value to q.15 and clamp to +-32767
    function automatic logic signed [TRIG_W-1:0] to_trig(input logic signed [CX_W-1:0] v);
        logic signed [CX_W:0]  t;
        logic signed [Q_W-1:0] r;
        t = (CX_W + 1)'(v) + (CX_W + 1)'(ROUND_HALF);
        r = Q_W'(t >>> TRIG_FRAC);
        if (r > Q_HI) begin
            r = Q_HI;
        end else if (r < Q_LO) begin
            r = Q_LO;
        end
        return TRIG_W'(r);
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [OSUM_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if ((&v[OSUM_W-1:COORD_W-1]) || !(|v[OSUM_W-1:COORD_W-1])) begin
            r = COORD_W'(v);
        end else if (v[OSUM_W-1]) begin
            r = $signed({1'b1, {(COORD_W - 1){1'b0}}});
        end else begin
            r = $signed({1'b0, {(COORD_W - 1){1'b1}}});
        end
        return r;
    endfunction

    // pipeline control
    logic [NUM_ST-1:0] r_v;
    logic [NUM_ST-1:0] n_v;
    logic [NUM_ST-1:0] rdy;

    // cordic stages and the transaction travelling beside them
    t_cordic  r_cord [CORDIC_STAGES];
    t_cordic  n_cord [CORDIC_STAGES];
    t_in_item r_item [CORDIC_STAGES+1];
    t_in_item n_item [CORDIC_STAGES+1];

    logic [TURN_W-1:0] turn;
    t_cordic           cord_start;

    // trig stage
    logic [QUAD_W-1:0]        quad;
    logic signed [TRIG_W-1:0] c_raw;
    logic signed [TRIG_W-1:0] s_raw;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] n_cos;
    logic signed [TRIG_W-1:0] n_sin;

    // multiply stage
    logic signed [PROD_W-1:0]  r_p_xc, r_p_ys, r_p_xs, r_p_yc;
    logic signed [PROD_W-1:0]  n_p_xc, n_p_ys, n_p_xs, n_p_yc;
    logic signed [COORD_W-1:0] r_mul_pose_x, r_mul_pose_y;

    // rotation stage
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic signed [ROT_W-1:0]   r_rot_x, r_rot_y;
    logic signed [ROT_W-1:0]   n_rot_x, n_rot_y;
    logic signed [COORD_W-1:0] r_rot_pose_x, r_rot_pose_y;

    // output stage
    logic signed [OSUM_W-1:0] osum_x, osum_y;
    t_out_item                r_out;
    t_out_item                n_out;

    // ready ripples back from the output; an empty stage always takes data
    always_comb begin
        rdy[NUM_ST-1] = !r_v[NUM_ST-1] || i_out_ready;
        for (int k = NUM_ST - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
        n_v[0] = rdy[0] ? i_in_valid : r_v[0];
        for (int k = 1; k < NUM_ST; k++) begin
            if (rdy[k]) begin
                n_v[k] = r_v[k-1];
            end else begin
                n_v[k] = r_v[k];
            end
        end
    end

    // heading widened to a turn fraction, the quadrant bits are mapped later
    always_comb begin
        turn         = TURN_W'(i_in_data.heading) << (TURN_W - ANGLE_W);
        cord_start.x = CORDIC_START;
        cord_start.y = '0;
        cord_start.z = CZ_W'(turn[TURN_W-QUAD_W-1:0]);
    end

    always_comb begin
        t_cordic t;
        t = cord_start;
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                t = cordic_step(t, STEP_IDX_W'(k * STEPS_PER_STAGE + j));
            end
            n_cord[k] = t;
            // the next stage starts from this stage's register
            t = r_cord[k];
        end
        n_item[0] = i_in_data;
        for (int k = 1; k <= CORDIC_STAGES; k++) begin
            n_item[k] = r_item[k-1];
        end
    end

    // rounding and quadrant mapping
    always_comb begin
        quad  = r_item[CORDIC_STAGES-1].heading[ANGLE_W-1 -: QUAD_W];
        c_raw = to_trig(r_cord[CORDIC_STAGES-1].x);
        s_raw = to_trig(r_cord[CORDIC_STAGES-1].y);
        unique case (quad)
            QUAD_0: begin
                n_cos = c_raw;
                n_sin = s_raw;
            end
            QUAD_1: begin
                n_cos = -s_raw;
                n_sin = c_raw;
            end
            QUAD_2: begin
                n_cos = -c_raw;
                n_sin = -s_raw;
            end
            QUAD_3: begin
                n_cos = s_raw;
                n_sin = -c_raw;
            end
        endcase
    end

    // four independent 32x16 products
    always_comb begin
        n_p_xc = PROD_W'(r_item[ST_TRIG].point_x) * PROD_W'(r_cos);
        n_p_ys = PROD_W'(r_item[ST_TRIG].point_y) * PROD_W'(r_sin);
        n_p_xs = PROD_W'(r_item[ST_TRIG].point_x) * PROD_W'(r_sin);
        n_p_yc = PROD_W'(r_item[ST_TRIG].point_y) * PROD_W'(r_cos);
    end

    // rotation sums, rounded back to q.16
    always_comb begin
        sum_x   = SUM_W'(r_p_xc) - SUM_W'(r_p_ys) + SUM_W'(ROUND_HALF);
        sum_y   = SUM_W'(r_p_xs) + SUM_W'(r_p_yc) + SUM_W'(ROUND_HALF);
        n_rot_x = ROT_W'(sum_x >>> TRIG_FRAC);
        n_rot_y = ROT_W'(sum_y >>> TRIG_FRAC);
    end

    // translate and saturate
    always_comb begin
        osum_x        = OSUM_W'(r_rot_pose_x) + OSUM_W'(r_rot_x);
        osum_y        = OSUM_W'(r_rot_pose_y) + OSUM_W'(r_rot_y);
        n_out.world_x = sat_coord(osum_x);
        n_out.world_y = sat_coord(osum_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // payload registers load whenever their stage can move
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            if (rdy[k]) begin
                r_cord[k] <= n_cord[k];
                r_item[k] <= n_item[k];
            end
        end
        if (rdy[ST_TRIG]) begin
            r_cos           <= n_cos;
            r_sin           <= n_sin;
            r_item[ST_TRIG] <= n_item[ST_TRIG];
        end
        if (rdy[ST_MUL]) begin
            r_p_xc       <= n_p_xc;
            r_p_ys       <= n_p_ys;
            r_p_xs       <= n_p_xs;
            r_p_yc       <= n_p_yc;
            r_mul_pose_x <= r_item[ST_TRIG].pose_x;
            r_mul_pose_y <= r_item[ST_TRIG].pose_y;
        end
        if (rdy[ST_ROT]) begin
            r_rot_x      <= n_rot_x;
            r_rot_y      <= n_rot_y;
            r_rot_pose_x <= r_mul_pose_x;
            r_rot_pose_y <= r_mul_pose_y;
        end
        if (rdy[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_v[ST_OUT];
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // input back-pressure only once every stage holds a transaction
    a_ready_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_v)
    ) else $error("input stalled while a pipeline stage was empty");

    // transactions in flight change only by acceptances at either end
    a_occupancy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_v) == $past($countones(r_v))
                  + int'($past(i_in_valid && o_in_ready))
                  - int'($past(o_out_valid && i_out_ready)))
    ) else $error("transaction lost or duplicated in the pipeline");

    // clamped trig values never reach the negative full-scale code
    a_trig_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_TRIG] |-> (!(r_cos[TRIG_W-1] && !(|r_cos[TRIG_W-2:0]))
                          && !(r_sin[TRIG_W-1] && !(|r_sin[TRIG_W-2:0])))
    ) else $error("sine or cosine outside the clamped range");
`endif

endmodule
